FILE: rtl/bdc_pkg.sv
// Shared constants and command types for the de Casteljau Bezier evaluator.
package bdc_pkg;

  // Size of the control point table
  localparam int MAX_POINTS = 16;
  localparam int IDX_W      = $clog2(MAX_POINTS);
  localparam int CNT_W      = $clog2(MAX_POINTS + 1);

  // Field widths
  localparam int COORD_W = 16;
  localparam int T_W     = 17;
  localparam int DIFF_W  = COORD_W + 1;
  localparam int PROD_W  = DIFF_W + T_W + 1;
  localparam int FRAC_W  = 16;

  // t of exactly one, and point_count after reset
  localparam logic [T_W-1:0]   T_ONE    = T_W'(65536);
  localparam logic [CNT_W-1:0] PC_RESET = CNT_W'(4);

  // Item modes
  localparam logic MODE_WRITE = 1'b0;
  localparam logic MODE_EVAL  = 1'b1;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic             wr_pt;  // store the incoming point
    logic             load;   // copy table to the working line, latch t
    logic             mul;    // form the products of the head pair
    logic             acc;    // finish the lerp, shift, write the tail
    logic             drop;   // shift out the stale head at level end
    logic [IDX_W-1:0] tail;   // tail slot of the current level
  } bdc_cmd_t;

endpackage

FILE: rtl/bdc_ctrl.sv
// Sequencer for the Bezier evaluator: handshake, level and step counters.
module bdc_ctrl
  import bdc_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic             in_mode,
  input  logic             cfg_wr_en,
  input  logic [CNT_W-1:0] cfg_wr_data,
  output logic             busy,
  output logic             out_valid,
  output bdc_cmd_t         cmd
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MUL,
    ST_ACC,
    ST_DROP
  } state_t;

  state_t           state_r, state_nxt;
  logic [CNT_W-1:0] pc_r, pc_nxt;
  logic [CNT_W-1:0] lvl_r, lvl_nxt;
  logic [IDX_W-1:0] step_r, step_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic             accept;
  logic [CNT_W-1:0] n_pts;

  assign busy      = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;
  assign accept    = start && !busy;

  // Clamp the configured point count into 1..MAX_POINTS
  always_comb begin
    if (pc_r == '0) begin
      n_pts = CNT_W'(1);
    end else if (pc_r > CNT_W'(MAX_POINTS)) begin
      n_pts = CNT_W'(MAX_POINTS);
    end else begin
      n_pts = pc_r;
    end
  end

  // Commands to the datapath
  always_comb begin
    cmd.wr_pt = accept && (in_mode == MODE_WRITE);
    cmd.load  = accept && (in_mode == MODE_EVAL);
    cmd.mul   = (state_r == ST_MUL);
    cmd.acc   = (state_r == ST_ACC);
    cmd.drop  = (state_r == ST_DROP);
    cmd.tail  = IDX_W'(lvl_r - CNT_W'(1));
  end

  // Next state
  always_comb begin
    state_nxt     = state_r;
    lvl_nxt       = lvl_r;
    step_nxt      = step_r;
    out_valid_nxt = 1'b0;
    pc_nxt        = cfg_wr_en ? cfg_wr_data : pc_r;
    unique case (state_r)
      ST_IDLE: begin
        if (cmd.load) begin
          if (n_pts == CNT_W'(1)) begin
            out_valid_nxt = 1'b1;
          end else begin
            lvl_nxt   = n_pts;
            step_nxt  = '0;
            state_nxt = ST_MUL;
          end
        end
      end
      ST_MUL: begin
        state_nxt = ST_ACC;
      end
      ST_ACC: begin
        if ({1'b0, step_r} == lvl_r - CNT_W'(2)) begin
          state_nxt = ST_DROP;
        end else begin
          step_nxt  = step_r + IDX_W'(1);
          state_nxt = ST_MUL;
        end
      end
      ST_DROP: begin
        lvl_nxt  = lvl_r - CNT_W'(1);
        step_nxt = '0;
        if (lvl_r == CNT_W'(2)) begin
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end else begin
          state_nxt = ST_MUL;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // State and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      pc_r        <= PC_RESET;
      lvl_r       <= '0;
      step_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      pc_r        <= pc_nxt;
      lvl_r       <= lvl_nxt;
      step_r      <= step_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

FILE: rtl/bdc_dp.sv
// Datapath: point table, working shift line and the shared lerp unit.
module bdc_dp
  import bdc_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst_n,
  input  bdc_cmd_t                  cmd,
  input  logic [IDX_W-1:0]          in_point_index,
  input  logic signed [COORD_W-1:0] in_point_x,
  input  logic signed [COORD_W-1:0] in_point_y,
  input  logic [T_W-1:0]            in_t_param,
  output logic signed [COORD_W-1:0] out_curve_x,
  output logic signed [COORD_W-1:0] out_curve_y
);

  logic signed [COORD_W-1:0] pts_x_r [MAX_POINTS];
  logic signed [COORD_W-1:0] pts_y_r [MAX_POINTS];
  logic signed [COORD_W-1:0] w_x_r   [MAX_POINTS];
  logic signed [COORD_W-1:0] w_y_r   [MAX_POINTS];
  logic [T_W-1:0]            t_r;
  logic signed [PROD_W-1:0]  prod_x_r, prod_y_r;
  logic signed [COORD_W-1:0] a_x_r, a_y_r;

  logic signed [DIFF_W-1:0]  diff_x, diff_y;
  logic signed [T_W:0]       t_s;
  logic signed [PROD_W-1:0]  prod_x, prod_y;
  logic [DIFF_W-1:0]         sum_x, sum_y;
  logic signed [COORD_W-1:0] lerp_x, lerp_y;
  logic [T_W-1:0]            t_sat;

  // Saturate t at one
  assign t_sat = (in_t_param > T_ONE) ? T_ONE : in_t_param;

  // Head pair difference times t
  assign diff_x = DIFF_W'(w_x_r[1]) - DIFF_W'(w_x_r[0]);
  assign diff_y = DIFF_W'(w_y_r[1]) - DIFF_W'(w_y_r[0]);
  assign t_s    = $signed({1'b0, t_r});
  assign prod_x = diff_x * t_s;
  assign prod_y = diff_y * t_s;

  // a + floor(prod / 2^16); the result stays inside the coordinate range
  assign sum_x  = {a_x_r[COORD_W-1], a_x_r} + prod_x_r[FRAC_W +: DIFF_W];
  assign sum_y  = {a_y_r[COORD_W-1], a_y_r} + prod_y_r[FRAC_W +: DIFF_W];
  assign lerp_x = $signed(sum_x[COORD_W-1:0]);
  assign lerp_y = $signed(sum_y[COORD_W-1:0]);

  assign out_curve_x = w_x_r[0];
  assign out_curve_y = w_y_r[0];

  // Control point table, cleared at reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < MAX_POINTS; i++) begin
        pts_x_r[i] <= '0;
        pts_y_r[i] <= '0;
      end
    end else if (cmd.wr_pt && (int'(in_point_index) < MAX_POINTS)) begin
      pts_x_r[in_point_index] <= in_point_x;
      pts_y_r[in_point_index] <= in_point_y;
    end
  end

  // Product stage
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      t_r <= t_sat;
    end
    if (cmd.mul) begin
      prod_x_r <= prod_x;
      prod_y_r <= prod_y;
      a_x_r    <= w_x_r[0];
      a_y_r    <= w_y_r[0];
    end
  end

  // Working line: shift towards the head, new values enter at the tail
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      for (int i = 0; i < MAX_POINTS; i++) begin
        w_x_r[i] <= pts_x_r[i];
        w_y_r[i] <= pts_y_r[i];
      end
    end else if (cmd.acc || cmd.drop) begin
      for (int i = 0; i < MAX_POINTS - 1; i++) begin
        w_x_r[i] <= w_x_r[i+1];
        w_y_r[i] <= w_y_r[i+1];
      end
      if (cmd.acc) begin
        w_x_r[cmd.tail] <= lerp_x;
        w_y_r[cmd.tail] <= lerp_y;
      end
    end
  end

endmodule

FILE: rtl/bezier_de_casteljau_eval.sv
// Top level of the fixed-point de Casteljau Bezier curve evaluator.
//
//   channel  | ports                                        | handshake
//   ---------+----------------------------------------------+------------------------
//   input    | in_mode in_point_index in_point_x/y in_t_param | start high, busy low
//   result   | out_curve_x out_curve_y                      | out_valid, one cycle
//   config   | cfg_wr_data (point_count)                    | cfg_wr_en
//
// A point write does not raise busy. An evaluation with n > 1 points keeps busy
// high while each interpolation passes through the shared multiplier pair in a
// product step and an accumulate step, and each level ends with a step that drops
// the stale head; the result strobes as busy falls. Reset clears the point table
// and sets point_count to 4. The receiver cannot stall.
module bezier_de_casteljau_eval
  import bdc_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  output logic                      busy,
  input  logic                      in_mode,
  input  logic [IDX_W-1:0]          in_point_index,
  input  logic signed [COORD_W-1:0] in_point_x,
  input  logic signed [COORD_W-1:0] in_point_y,
  input  logic [T_W-1:0]            in_t_param,
  output logic                      out_valid,
  output logic signed [COORD_W-1:0] out_curve_x,
  output logic signed [COORD_W-1:0] out_curve_y,
  input  logic                      cfg_wr_en,
  input  logic [CNT_W-1:0]          cfg_wr_data
);

  bdc_cmd_t cmd;

  bdc_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .in_mode     (in_mode),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .busy        (busy),
    .out_valid   (out_valid),
    .cmd         (cmd)
  );

  bdc_dp u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .in_point_index (in_point_index),
    .in_point_x     (in_point_x),
    .in_point_y     (in_point_y),
    .in_t_param     (in_t_param),
    .out_curve_x    (out_curve_x),
    .out_curve_y    (out_curve_y)
  );

`ifndef SYNTHESIS
  // A point write never starts a busy period
  a_write_no_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_mode == MODE_WRITE) |=> !busy)
    else $error("busy after a point write");

  // An evaluation either answers at once or goes busy
  a_eval_progress: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_mode == MODE_EVAL) |=> (busy || out_valid))
    else $error("evaluation neither busy nor answered");

  // The end of a busy period always carries a result
  a_busy_end_result: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(busy) |-> out_valid)
    else $error("busy ended without a result");

  // A result is only shown once the sequencer is free
  a_result_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result strobe while busy");
`endif

endmodule
